FILE: hdl/slfp_pkg.sv
// Shared types and constants for the sync/length frame parser.
package slfp_pkg;

  localparam logic [7:0] SYNC_RESET = 8'h7E;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_FRAME   = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT1 = 3'd0,
    PH_HUNT2 = 3'd1,
    PH_CMD   = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHK1  = 3'd5,
    PH_CHK2  = 3'd6
  } phase_t;

endpackage

FILE: hdl/sync_length_frame_parser.sv
// Sync/length frame parser: deframes a received byte stream into payload words.
//
// Input channel (in_*): one received byte per word. A frame is two sync bytes,
// a command byte, a length byte, that many payload bytes and two check bytes.
// The check bytes are consumed but not verified.
// Output channel (out_*): one word per payload byte (kind 0, with index and a
// last mark) and one frame-complete word (kind 1) after the second check byte,
// both carrying the command and length of the frame.
// Config channel (cfg_*): writes the sync byte value; always ready. Write it
// only while no input word is in flight.
// Output: a result is registered into the output register as its input word is
// accepted. Throughput: one input word per cycle while the output is not stalled,
// set by the single parse-state update between the input port and the output register.
// Reset: the parser hunts for the first sync byte, the sync value returns to
// 0x7E and the output register is empty.
// Stall: while a result waits in the output register and out_ready is low,
// in_ready drops; the parser state and the held result stay put.
module sync_length_frame_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_result_kind,
  output logic [7:0] out_payload_byte,
  output logic [7:0] out_payload_index,
  output logic       out_payload_last,
  output logic [7:0] out_command,
  output logic [7:0] out_frame_length,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_sync_value
);
  import slfp_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] sync_r;
  logic [7:0] count_r, count_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cmd_r, cmd_nxt;

  logic       out_valid_r;
  logic       kind_r, kind_nxt;
  logic [7:0] pbyte_r, pbyte_nxt;
  logic [7:0] pidx_r, pidx_nxt;
  logic       plast_r, plast_nxt;
  logic [7:0] ocmd_r, ocmd_nxt;
  logic [7:0] olen_r, olen_nxt;
  logic       emit;
  logic       accept;
  logic       last;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign last      = ({1'b0, count_r} + 9'd1) >= {1'b0, len_r};

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    len_nxt   = len_r;
    cmd_nxt   = cmd_r;
    emit      = 1'b0;
    kind_nxt  = KIND_PAYLOAD;
    pbyte_nxt = 8'd0;
    pidx_nxt  = 8'd0;
    plast_nxt = 1'b0;
    ocmd_nxt  = cmd_r;
    olen_nxt  = len_r;
    unique case (phase_r)
      PH_HUNT1: begin
        if (in_rx_byte == sync_r) phase_nxt = PH_HUNT2;
      end
      PH_HUNT2: begin
        phase_nxt = (in_rx_byte == sync_r) ? PH_CMD : PH_HUNT1;
      end
      PH_CMD: begin
        cmd_nxt   = in_rx_byte;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        count_nxt = 8'd0;
        len_nxt   = in_rx_byte;
        phase_nxt = (in_rx_byte == 8'd0) ? PH_CHK1 : PH_DATA;
      end
      PH_DATA: begin
        emit      = 1'b1;
        pbyte_nxt = in_rx_byte;
        pidx_nxt  = count_r;
        plast_nxt = last;
        count_nxt = count_r + 8'd1;
        if (last) phase_nxt = PH_CHK1;
      end
      PH_CHK1: begin
        phase_nxt = PH_CHK2;
      end
      PH_CHK2: begin
        emit      = 1'b1;
        kind_nxt  = KIND_FRAME;
        phase_nxt = PH_HUNT1;
      end
      default: begin
        // unused phase code: drop the byte and go back to hunting
        phase_nxt = PH_HUNT1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT1;
      sync_r      <= SYNC_RESET;
      count_r     <= 8'd0;
      len_r       <= 8'd0;
      cmd_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) sync_r <= cfg_sync_value;
      if (accept) begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
        len_r   <= len_nxt;
        cmd_r   <= cmd_nxt;
        out_valid_r <= emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the result fields until an accepted word produces a new result
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      kind_r  <= kind_nxt;
      pbyte_r <= pbyte_nxt;
      pidx_r  <= pidx_nxt;
      plast_r <= plast_nxt;
      ocmd_r  <= ocmd_nxt;
      olen_r  <= olen_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = kind_r;
  assign out_payload_byte  = pbyte_r;
  assign out_payload_index = pidx_r;
  assign out_payload_last  = plast_r;
  assign out_command       = ocmd_r;
  assign out_frame_length  = olen_r;

endmodule

FILE: hdl/slfp_checker.sv
// Port-level checker for the sync/length frame parser, with its bind.
module slfp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_result_kind,
  input logic [7:0] out_payload_byte,
  input logic [7:0] out_payload_index,
  input logic       out_payload_last,
  input logic [7:0] out_frame_length
);
  import slfp_pkg::*;

  // a result under stall stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_FRAME |->
      out_payload_byte == 8'd0 && out_payload_index == 8'd0 && !out_payload_last)
    else $error("frame-complete word carries payload fields");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_PAYLOAD |->
      out_payload_index < out_frame_length)
    else $error("payload index beyond frame length");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_PAYLOAD |->
      out_payload_last ==
        (({1'b0, out_payload_index} + 9'd1) == {1'b0, out_frame_length}))
    else $error("last mark not on final payload byte");

endmodule

bind sync_length_frame_parser slfp_checker u_slfp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_result_kind   (out_result_kind),
  .out_payload_byte  (out_payload_byte),
  .out_payload_index (out_payload_index),
  .out_payload_last  (out_payload_last),
  .out_frame_length  (out_frame_length)
);
